FILE: hdl/cdq_pkg.sv
package cdq_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 6;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int CAP_W   = 7;

    // Packed stream widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 48;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEFAULT     = 64;
    localparam int ITEM_BITS_DEFAULT = 32;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ_BACK  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ_AT    = 3'd6;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd7;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

FILE: hdl/circular_deque_core.sv
// Double-ended queue held in a ring memory of DEPTH entries, of which the
// first "capacity" entries are in use.
// Input channel (s_*): one transaction carries one operation. The operation
// code travels in s_tuser; the push word and the read_at index in s_tdata.
// Result channel (m_*): every operation gives exactly one result transaction
// with the read word, a status code, the item count after the operation and
// the full and empty flags.
// Configuration: a pulse on cfg_we loads the capacity from cfg_wdata and also
// empties the queue. Write it only while no result is outstanding.
// Result timing: a result appears in the cycle after its operation is
// accepted; the ring memory has a synchronous read, registered on accept.
// Throughput: one operation per cycle unless stalled. Pointers and count
// live in flip-flops and are updated in the accepting cycle; a write lands in
// memory before any later read, so back-to-back ops need no interlock.
// Stall: when m_tready is low, the result register holds its transaction and
// s_tready drops until the result is taken; nothing is lost or repeated.
// Reset (aresetn low, synchronous): the queue is empty, pointers are zero
// and the capacity is 64. Memory contents are not cleared; entries inside
// the count are always written before they are read, so no clearing pass
// is needed and the block accepts operations right after reset.
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Capacity register write.
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,

    // Operation stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: push_data [31:0], index [37:32], zero [39:38]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: func [2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,

    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: read_data [31:0], status [33:32], count [40:34],
    //          is_full [41], is_empty [42], zero [47:43]
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Pointer width covers the built depth; arithmetic is done one bit
    // wider than the larger of pointer and count so compares never wrap.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

    // Unpacked input fields.
    logic [FUNC_W-1:0]  in_func;
    logic [DATA_W-1:0]  in_data;
    logic [INDEX_W-1:0] in_index;

    assign in_func  = s_tuser;
    assign in_data  = s_tdata[DATA_W-1:0];
    assign in_index = s_tdata[DATA_W+INDEX_W-1:DATA_W];

    // Control state.
    logic [CAP_W-1:0] cap_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Result register.
    logic              out_valid_reg;
    logic              out_is_read_reg, out_is_read_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_full_reg, out_full_next;
    logic              out_empty_reg;

    // Ring memory and its registered read port.
    logic [ITEM_BITS-1:0] ring_mem [DEPTH];
    logic [ITEM_BITS-1:0] rd_data_reg;

    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    logic [PTR_W-1:0]     mem_raddr;
    logic [ITEM_BITS-1:0] mem_wdata;
    logic [63:0]          push_wide;
    logic [63:0]          rd_wide;

    logic accept;

    // The result register frees up in the same cycle it is drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Effective capacity: zero acts as one, anything above the depth as
    // the depth.
    logic [CW-1:0] cap_eff;
    logic [CW-1:0] cap_ext;

    assign cap_ext = CW'(cap_reg);

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (cap_ext > CW'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    // Ring neighbors of head and tail, and the read_at position. An upward wrap
    // is one compare and subtract of the capacity; below zero wraps to cap-1.
    logic [CW-1:0] head_ext, tail_ext, count_ext;
    logic [CW-1:0] head_inc, head_dec, tail_inc, tail_dec, at_pos;
    logic [CW-1:0] head_plus1, tail_plus1, head_plus_idx;

    assign head_ext      = CW'(head_reg);
    assign tail_ext      = CW'(tail_reg);
    assign count_ext     = CW'(count_reg);
    assign head_plus1    = head_ext + CW'(1);
    assign tail_plus1    = tail_ext + CW'(1);
    assign head_plus_idx = head_ext + CW'(in_index);

    assign head_inc = (head_plus1 >= cap_eff) ? (head_plus1 - cap_eff) : head_plus1;
    assign tail_inc = (tail_plus1 >= cap_eff) ? (tail_plus1 - cap_eff) : tail_plus1;
    assign head_dec = (head_reg == '0) ? (cap_eff - CW'(1)) : (head_ext - CW'(1));
    assign tail_dec = (tail_reg == '0) ? (cap_eff - CW'(1)) : (tail_ext - CW'(1));
    assign at_pos   = (head_plus_idx >= cap_eff) ? (head_plus_idx - cap_eff)
                                                 : head_plus_idx;

    logic q_full, q_empty;

    assign q_full  = (count_ext >= cap_eff);
    assign q_empty = (count_reg == '0);

    // Stored words keep the low ITEM_BITS of the push word.
    assign push_wide = 64'(in_data);
    assign mem_wdata = push_wide[ITEM_BITS-1:0];

    // Operation decode: next pointers, memory access and result fields.
    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        mem_we           = 1'b0;
        mem_waddr        = tail_reg;
        mem_raddr        = head_reg;
        out_status_next  = ST_OK;
        out_is_read_next = 1'b0;

        case (in_func)
            FN_PUSH_BACK: begin
                if (q_full) begin
                    out_status_next = ST_FULL;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = tail_reg;
                    tail_next  = tail_inc[PTR_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_PUSH_FRONT: begin
                if (q_full) begin
                    out_status_next = ST_FULL;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = head_dec[PTR_W-1:0];
                    head_next  = head_dec[PTR_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_POP_FRONT: begin
                if (q_empty) begin
                    out_status_next = ST_EMPTY;
                end else begin
                    head_next  = head_inc[PTR_W-1:0];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            FN_POP_BACK: begin
                if (q_empty) begin
                    out_status_next = ST_EMPTY;
                end else begin
                    tail_next  = tail_dec[PTR_W-1:0];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            FN_READ_FRONT: begin
                if (q_empty) begin
                    out_status_next = ST_EMPTY;
                end else begin
                    mem_raddr        = head_reg;
                    out_is_read_next = 1'b1;
                end
            end
            FN_READ_BACK: begin
                if (q_empty) begin
                    out_status_next = ST_EMPTY;
                end else begin
                    mem_raddr        = tail_dec[PTR_W-1:0];
                    out_is_read_next = 1'b1;
                end
            end
            FN_READ_AT: begin
                if (q_empty) begin
                    out_status_next = ST_EMPTY;
                end else if (CNT_W'(in_index) >= count_reg) begin
                    out_status_next = ST_RANGE;
                end else begin
                    mem_raddr        = at_pos[PTR_W-1:0];
                    out_is_read_next = 1'b1;
                end
            end
            FN_CLEAR: begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default: begin
                head_next = head_reg;
            end
        endcase

        out_full_next = (CW'(count_next) == cap_eff);
    end

    // Ring memory: one write port and one registered read port. The read
    // register only moves on an accepted operation so it holds during a
    // stall of the result channel.
    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= ring_mem[mem_raddr];
        end
    end

    // Control state and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                // A capacity write also empties the queue.
                cap_reg   <= cfg_wdata;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end else if (accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end

            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_is_read_reg <= out_is_read_next;
            out_status_reg  <= out_status_next;
            out_count_reg   <= count_next;
            out_full_reg    <= out_full_next;
            out_empty_reg   <= (count_next == '0);
        end
    end

    // Read data is zero for everything but a successful read.
    assign rd_wide = out_is_read_reg ? 64'(rd_data_reg) : 64'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_empty_reg, out_full_reg, out_count_reg,
                       out_status_reg, rd_wide[DATA_W-1:0]};

endmodule
